// ----- rtl/kts_pkg.sv -----
// shared types for the key/tag partition sorter
`timescale 1ns / 1ps

package kts_pkg;

    // step taken by one compare of the two-pointer sweep
    typedef enum logic [1:0] {
        SW_BOTH  = 2'd0,   // both sides in place: advance both pointers
        SW_LEFT  = 2'd1,   // only the left side in place
        SW_RIGHT = 2'd2,   // only the right side in place
        SW_SWAP  = 2'd3    // both misplaced: exchange then advance both
    } t_sweep_act;

endpackage

// ----- rtl/key_tag_partition_sort.sv -----
// key/tag partition sorter: element store, range stack and sort sequencer
`timescale 1ns / 1ps

// usage
//   input channel: a transaction (i_key, i_tag, i_is_last) is taken at a rising
//   edge with start high and busy low, one per cycle while busy is low; the
//   item marked i_is_last ends the list and starts the sort. elements past
//   MAX_ELEMENTS are dropped and the run is flagged overflowed.
//   result channel: each sorted element sits on o_sorted_key / o_sorted_tag
//   for exactly one cycle with o_strobe high; o_end_of_list marks the last,
//   o_overflowed is set on every result of a run that dropped elements.
//   the receiver cannot stall, so results flow at a fixed pace.
// sorting
//   one element memory (two registered read ports, one write port) and one
//   shared compare stage serve the sort. a partitioned range of length L is
//   read once to count keys below its middle pivot, the pivot is exchanged
//   into its slot, then a sweep of up to L - 1 steps follows, an exchange
//   adding a write state; a two-element range swaps unless strictly ascending.
//   each result is read, then sent, before the next read. many equal keys
//   push the sort toward quadratic time.
// reset
//   synchronous, active low: the sequencer idles, the fill count, overflow
//   flag and stack pointer clear; the memories keep their contents.
module key_tag_partition_sort
    import kts_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int KEY_BITS     = 32,
    parameter int TAG_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic signed [KEY_BITS-1:0] i_key,
    input  logic        [TAG_BITS-1:0] i_tag,
    input  logic                       i_is_last,
    output logic                       busy,
    output logic                       o_strobe,
    output logic signed [KEY_BITS-1:0] o_sorted_key,
    output logic        [TAG_BITS-1:0] o_sorted_tag,
    output logic                       o_end_of_list,
    output logic                       o_overflowed
);

    localparam int AW = $clog2(MAX_ELEMENTS);      // element address
    localparam int CW = $clog2(MAX_ELEMENTS + 1);  // counts up to the depth
    localparam int PW = CW + 1;                    // sums of two counts
    localparam int EW = KEY_BITS + TAG_BITS;       // stored element {key, tag}
    localparam int SW = AW + CW;                   // stack entry {base, len}

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_DECODE,
        S_PAIR,
        S_PAIR_WR,
        S_PIV,
        S_COUNT,
        S_PLACE,
        S_PLACE_WR,
        S_PLACE_WR2,
        S_SWEEP_RD,
        S_SWEEP_CMP,
        S_SWEEP_WR,
        S_PUSH_L,
        S_PUSH_R,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    // element memory and range stack
    logic [EW-1:0] r_mem [MAX_ELEMENTS];
    logic [SW-1:0] r_stk [MAX_ELEMENTS];
    logic [EW-1:0] r_rd_a, r_rd_b;
    logic [SW-1:0] r_stk_q;

    // sequencer registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_fill,  n_fill;
    logic          r_ovf,   n_ovf;
    logic [CW-1:0] r_sp,    n_sp;
    logic [AW-1:0] r_base,  n_base;
    logic [CW-1:0] r_len,   n_len;
    logic [CW-1:0] r_k,     n_k;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [AW-1:0] r_i,     n_i;
    logic [AW-1:0] r_j,     n_j;
    logic [CW-1:0] r_o,     n_o;
    logic [EW-1:0] r_piv,   n_piv;

    // registered result port
    logic                       r_strobe, n_strobe;
    logic signed [KEY_BITS-1:0] r_okey,   n_okey;
    logic        [TAG_BITS-1:0] r_otag,   n_otag;
    logic                       r_oend,   n_oend;
    logic                       r_oovf,   n_oovf;

    // memory port controls
    logic          w_re, w_we, w_sre, w_swe;
    logic [AW-1:0] w_ra, w_rb, w_wa;
    logic [EW-1:0] w_wd;
    logic [AW-1:0] w_sra, w_swa;
    logic [SW-1:0] w_swd;

    // decoded range and shared compare unit
    logic [AW-1:0]              w_top_base;
    logic [CW-1:0]              w_top_len;
    logic [AW-1:0]              w_mid, w_pivpos;
    logic signed [KEY_BITS-1:0] w_key_a, w_key_b, w_key_p;
    logic                       w_lt_a, w_lt_b;
    t_sweep_act                 w_act;

    assign w_top_base = r_stk_q[SW-1:CW];
    assign w_top_len  = r_stk_q[CW-1:0];
    assign w_mid      = AW'(PW'(r_base) + PW'(r_len >> 1));
    assign w_pivpos   = AW'(PW'(r_base) + PW'(r_cnt));

    assign w_key_a = r_rd_a[EW-1:TAG_BITS];
    assign w_key_b = r_rd_b[EW-1:TAG_BITS];
    assign w_key_p = r_piv[EW-1:TAG_BITS];
    assign w_lt_a  = w_key_a < w_key_p;
    assign w_lt_b  = w_key_b < w_key_p;

    always_comb begin
        case ({w_lt_a, w_lt_b})
            2'b10:   w_act = SW_BOTH;
            2'b11:   w_act = SW_LEFT;
            2'b00:   w_act = SW_RIGHT;
            default: w_act = SW_SWAP;
        endcase
    end

    // element memory: two registered read ports, one write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_a <= r_mem[w_ra];
            r_rd_b <= r_mem[w_rb];
        end
    end

    // range stack memory
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_stk[w_swa] <= w_swd;
        end
        if (w_sre) begin
            r_stk_q <= r_stk[w_sra];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_ovf    = r_ovf;
        n_sp     = r_sp;
        n_base   = r_base;
        n_len    = r_len;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_o      = r_o;
        n_piv    = r_piv;
        n_strobe = 1'b0;
        n_okey   = r_okey;
        n_otag   = r_otag;
        n_oend   = r_oend;
        n_oovf   = r_oovf;

        w_re  = 1'b0;
        w_ra  = r_i;
        w_rb  = r_j;
        w_we  = 1'b0;
        w_wa  = r_i;
        w_wd  = r_rd_b;
        w_sre = 1'b0;
        w_sra = AW'(r_sp - CW'(1));
        w_swe = 1'b0;
        w_swa = r_sp[AW-1:0];
        w_swd = {r_base, r_cnt};

        case (r_state)
            // load one transaction per cycle until the last one
            S_IDLE: begin
                if (start) begin
                    if (r_fill < CW'(MAX_ELEMENTS)) begin
                        w_we   = 1'b1;
                        w_wa   = r_fill[AW-1:0];
                        w_wd   = {i_key, i_tag};
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            // whole list, if it holds two or more elements, is the first pending range
            S_INIT: begin
                n_sp = '0;
                if (r_fill >= CW'(2)) begin
                    w_swe = 1'b1;
                    w_swa = '0;
                    w_swd = {AW'(0), r_fill};
                    n_sp  = CW'(1);
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_o     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    w_sre   = 1'b1;
                    n_sp    = r_sp - CW'(1);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_base = w_top_base;
                n_len  = w_top_len;
                if (PW'(w_top_base) + PW'(w_top_len) > PW'(r_fill)) begin
                    n_state = S_POP;
                end else if (w_top_len == CW'(2)) begin
                    w_re    = 1'b1;
                    w_ra    = w_top_base;
                    w_rb    = AW'(PW'(w_top_base) + PW'(1));
                    n_state = S_PAIR;
                end else if (w_top_len > CW'(2)) begin
                    w_re    = 1'b1;
                    w_ra    = AW'(PW'(w_top_base) + PW'(w_top_len >> 1));
                    n_state = S_PIV;
                end else begin
                    n_state = S_POP;
                end
            end
            // two-element range swaps unless strictly ascending
            S_PAIR: begin
                if (!(w_key_a < w_key_b)) begin
                    w_we    = 1'b1;
                    w_wa    = r_base;
                    w_wd    = r_rd_b;
                    n_state = S_PAIR_WR;
                end else begin
                    n_state = S_POP;
                end
            end
            S_PAIR_WR: begin
                w_we    = 1'b1;
                w_wa    = AW'(PW'(r_base) + PW'(1));
                w_wd    = r_rd_a;
                n_state = S_POP;
            end
            // latch the middle element, start counting smaller keys
            S_PIV: begin
                n_piv   = r_rd_a;
                w_re    = 1'b1;
                w_ra    = r_base;
                n_k     = '0;
                n_cnt   = '0;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                if (w_lt_a) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_k == r_len - CW'(1)) begin
                    n_state = S_PLACE;
                end else begin
                    w_re = 1'b1;
                    w_ra = AW'(PW'(r_base) + PW'(r_k) + PW'(1));
                    n_k  = r_k + CW'(1);
                end
            end
            // exchange pivot into its final slot
            S_PLACE: begin
                w_re    = 1'b1;
                w_ra    = w_pivpos;
                n_state = S_PLACE_WR;
            end
            S_PLACE_WR: begin
                w_we    = 1'b1;
                w_wa    = w_mid;
                w_wd    = r_rd_a;
                n_state = S_PLACE_WR2;
            end
            S_PLACE_WR2: begin
                w_we    = 1'b1;
                w_wa    = w_pivpos;
                w_wd    = r_piv;
                n_i     = r_base;
                n_j     = AW'(PW'(r_base) + PW'(r_len) - PW'(1));
                n_state = S_SWEEP_RD;
            end
            // two-pointer sweep around the pivot
            S_SWEEP_RD: begin
                if (r_i < w_pivpos && r_j > w_pivpos) begin
                    w_re    = 1'b1;
                    w_ra    = r_i;
                    w_rb    = r_j;
                    n_state = S_SWEEP_CMP;
                end else begin
                    n_state = S_PUSH_L;
                end
            end
            S_SWEEP_CMP: begin
                n_state = S_SWEEP_RD;
                case (w_act)
                    SW_BOTH: begin
                        n_i = r_i + AW'(1);
                        n_j = r_j - AW'(1);
                    end
                    SW_LEFT: begin
                        n_i = r_i + AW'(1);
                    end
                    SW_RIGHT: begin
                        n_j = r_j - AW'(1);
                    end
                    default: begin
                        w_we    = 1'b1;
                        w_wa    = r_i;
                        w_wd    = r_rd_b;
                        n_state = S_SWEEP_WR;
                    end
                endcase
            end
            S_SWEEP_WR: begin
                w_we    = 1'b1;
                w_wa    = r_j;
                w_wd    = r_rd_a;
                n_i     = r_i + AW'(1);
                n_j     = r_j - AW'(1);
                n_state = S_SWEEP_RD;
            end
            // left side pushed first so the right side is sorted first
            S_PUSH_L: begin
                if (r_cnt > CW'(1) && r_sp < CW'(MAX_ELEMENTS)) begin
                    w_swe = 1'b1;
                    w_swd = {r_base, r_cnt};
                    n_sp  = r_sp + CW'(1);
                end
                n_state = S_PUSH_R;
            end
            S_PUSH_R: begin
                if (PW'(r_cnt) + PW'(2) < PW'(r_len) && r_sp < CW'(MAX_ELEMENTS)) begin
                    w_swe = 1'b1;
                    w_swd = {AW'(PW'(r_base) + PW'(r_cnt) + PW'(1)),
                             CW'(r_len - r_cnt - CW'(1))};
                    n_sp  = r_sp + CW'(1);
                end
                n_state = S_POP;
            end
            // stream the sorted store out
            S_OUT_RD: begin
                w_re    = 1'b1;
                w_ra    = r_o[AW-1:0];
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                n_strobe = 1'b1;
                n_okey   = w_key_a;
                n_otag   = r_rd_a[TAG_BITS-1:0];
                n_oend   = (r_o + CW'(1) == r_fill);
                n_oovf   = r_ovf;
                if (r_o + CW'(1) == r_fill) begin
                    n_fill  = '0;
                    n_ovf   = 1'b0;
                    n_sp    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_o     = r_o + CW'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_sp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_sp     <= n_sp;
            r_strobe <= n_strobe;
        end
        r_base <= n_base;
        r_len  <= n_len;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_j    <= n_j;
        r_o    <= n_o;
        r_piv  <= n_piv;
        r_okey <= n_okey;
        r_otag <= n_otag;
        r_oend <= n_oend;
        r_oovf <= n_oovf;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_sorted_key  = r_okey;
    assign o_sorted_tag  = r_otag;
    assign o_end_of_list = r_oend;
    assign o_overflowed  = r_oovf;

endmodule
